// ===== rtl/ifte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ifte_pkg;

   // Packet position counter.
   localparam int PACKET_LEN_BITS = 16;

   // Fixed IPv6 header layout, in byte positions.
   localparam int OFF_KIND      = 6;
   localparam int OFF_SRC_FIRST = 8;
   localparam int OFF_DST_FIRST = 24;
   localparam int FIXED_LEN     = 40;

   localparam logic [3:0] IP_VERSION_4 = 4'd4;

   // Next-header codes.
   localparam logic [7:0] HDR_HOP_BY_HOP = 8'd0;
   localparam logic [7:0] HDR_TCP        = 8'd6;
   localparam logic [7:0] HDR_UDP        = 8'd17;
   localparam logic [7:0] HDR_ROUTING    = 8'd43;
   localparam logic [7:0] HDR_FRAGMENT   = 8'd44;
   localparam logic [7:0] HDR_NO_NEXT    = 8'd59;
   localparam logic [7:0] HDR_DEST_OPT   = 8'd60;

   localparam int EXT_LEFT_BITS = 12;
   localparam logic [EXT_LEFT_BITS-1:0] PORT_BYTES = EXT_LEFT_BITS'(4);

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_FOUND       = 3'd0,
      ST_IPV4        = 3'd1,
      ST_EXT_SHORT   = 3'd2,
      ST_NO_NEXT     = 3'd3,
      ST_UNKNOWN     = 3'd4,
      ST_TRUNCATED   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_TCP  = 2'd1,
      KIND_UDP  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_FIXED,
      PH_EXT_NXT,
      PH_EXT_LEN,
      PH_EXT_SKIP,
      PH_PORTS,
      PH_DONE
   } phase_type;

   // Role of one byte inside the fixed header, worked out by the front.
   typedef struct packed {
      logic       is_first;
      logic       is_kind;
      logic       is_src;
      logic       is_dst;
      logic [3:0] addr_idx;
      logic       is_fixed_end;
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           last_byte;
      byte_class_type cls;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/ifte_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ifte_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/ifte_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ifte_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [1:0]  transport_kind;
   logic [15:0] source_port;
   logic [15:0] destination_port;
   logic [63:0] source_addr_high;
   logic [63:0] source_addr_low;
   logic [63:0] dest_addr_high;
   logic [63:0] dest_addr_low;

   modport source (output valid, output status, output transport_kind, output source_port,
                   output destination_port, output source_addr_high, output source_addr_low,
                   output dest_addr_high, output dest_addr_low, input ready);
   modport sink   (input valid, input status, input transport_kind, input source_port,
                   input destination_port, input source_addr_high, input source_addr_low,
                   input dest_addr_high, input dest_addr_low, output ready);
endinterface

`default_nettype wire

// ===== rtl/ifte_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ifte_front
   import ifte_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   ifte_req_if.sink   req_chan,
   input  wire logic  queue_ready,
   output logic       push,
   output entry_type  push_entry
);

   localparam logic [PACKET_LEN_BITS-1:0] OFFSET_MAX = {PACKET_LEN_BITS{1'b1}};

   logic [PACKET_LEN_BITS-1:0] offset_ff;
   logic [PACKET_LEN_BITS-1:0] offset_in;
   byte_class_type             cls;

   assign req_chan.ready = queue_ready;
   assign push           = req_chan.valid && queue_ready;

   always_comb begin
      cls.is_first     = (offset_ff == '0);
      cls.is_kind      = (offset_ff == PACKET_LEN_BITS'(OFF_KIND));
      cls.is_src       = (offset_ff >= PACKET_LEN_BITS'(OFF_SRC_FIRST)) &&
                         (offset_ff <  PACKET_LEN_BITS'(OFF_DST_FIRST));
      cls.is_dst       = (offset_ff >= PACKET_LEN_BITS'(OFF_DST_FIRST)) &&
                         (offset_ff <  PACKET_LEN_BITS'(FIXED_LEN));
      // Both address fields start on a multiple of eight that is odd in bit 3.
      cls.addr_idx     = {~offset_ff[3], offset_ff[2:0]};
      cls.is_fixed_end = (offset_ff == PACKET_LEN_BITS'(FIXED_LEN - 1));

      push_entry.data_byte = req_chan.data_byte;
      push_entry.last_byte = req_chan.last_byte;
      push_entry.cls       = cls;

      offset_in = offset_ff;
      if (push) begin
         if (req_chan.last_byte) begin
            offset_in = '0;
         end else if (offset_ff != OFFSET_MAX) begin
            offset_in = offset_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ifte_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ifte_queue
   import ifte_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   input  wire logic       pop,
   output logic            not_full,
   output logic            head_valid,
   output entry_type       head_entry
);

   entry_type                   slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]     count_ff, count_in;

   assign not_full   = (count_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ifte_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ifte_back
   import ifte_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire entry_type  head_entry,
   output logic            pop,
   ifte_rsp_if.source      rsp_chan
);

   phase_type                phase_ff, phase_in;
   logic [7:0]               kind_ff, kind_in;
   logic [EXT_LEFT_BITS-1:0] left_ff, left_in;
   logic [127:0]             src_ff, src_in;
   logic [127:0]             dst_ff, dst_in;
   logic [15:0]              psrc_ff, psrc_in;
   logic [15:0]              pdst_ff, pdst_in;
   kind_type                 found_ff, found_in;
   status_type               pstat_ff, pstat_in;

   // Outcome of starting the header named by kind_ff.
   phase_type                enter_phase;
   kind_type                 enter_found;
   logic [EXT_LEFT_BITS-1:0] enter_left;
   status_type               enter_stat;

   logic                     out_free;
   logic                     rsp_valid_ff;
   status_type               res_stat;
   logic                     res_found;
   logic [7:0]               b;

   logic [2:0]               o_status_ff;
   logic [1:0]               o_kind_ff;
   logic [15:0]              o_sport_ff, o_dport_ff;
   logic [127:0]             o_src_ff, o_dst_ff;

   assign b        = head_entry.data_byte;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = head_valid && (!head_entry.last_byte || out_free);

   always_comb begin
      enter_phase = PH_DONE;
      enter_found = found_ff;
      enter_left  = left_ff;
      enter_stat  = pstat_ff;
      case (kind_ff)
         HDR_HOP_BY_HOP, HDR_ROUTING, HDR_FRAGMENT, HDR_DEST_OPT: begin
            enter_phase = PH_EXT_NXT;
         end
         HDR_TCP: begin
            enter_found = KIND_TCP;
            enter_left  = PORT_BYTES;
            enter_phase = PH_PORTS;
         end
         HDR_UDP: begin
            enter_found = KIND_UDP;
            enter_left  = PORT_BYTES;
            enter_phase = PH_PORTS;
         end
         HDR_NO_NEXT: begin
            enter_stat = ST_NO_NEXT;
         end
         default: begin
            enter_stat = ST_UNKNOWN;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      left_in  = left_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      psrc_in  = psrc_ff;
      pdst_in  = pdst_ff;
      found_in = found_ff;
      pstat_in = pstat_ff;

      if (pop) begin
         case (phase_ff)
            PH_FIXED: begin
               if (head_entry.cls.is_first && (b[7:4] == IP_VERSION_4)) begin
                  pstat_in = ST_IPV4;
                  phase_in = PH_DONE;
               end else begin
                  if (head_entry.cls.is_kind) begin
                     kind_in = b;
                  end
                  if (head_entry.cls.is_src) begin
                     src_in[127 - 8 * head_entry.cls.addr_idx -: 8] = b;
                  end
                  if (head_entry.cls.is_dst) begin
                     dst_in[127 - 8 * head_entry.cls.addr_idx -: 8] = b;
                  end
                  if (head_entry.cls.is_fixed_end) begin
                     phase_in = enter_phase;
                     found_in = enter_found;
                     left_in  = enter_left;
                     pstat_in = enter_stat;
                  end
               end
            end
            PH_EXT_NXT: begin
               kind_in  = b;
               phase_in = PH_EXT_LEN;
            end
            PH_EXT_LEN: begin
               // (len + 1) * 8 bytes, of which the two just seen are gone.
               left_in  = {1'b0, b, 3'b000} + EXT_LEFT_BITS'(6);
               phase_in = PH_EXT_SKIP;
            end
            PH_EXT_SKIP: begin
               if (left_ff != '0) begin
                  left_in = left_ff - 1'b1;
               end
               if (left_in == '0) begin
                  phase_in = enter_phase;
                  found_in = enter_found;
                  left_in  = enter_left;
                  pstat_in = enter_stat;
               end
            end
            PH_PORTS: begin
               case (left_ff)
                  EXT_LEFT_BITS'(4): psrc_in = {b, 8'h00};
                  EXT_LEFT_BITS'(3): psrc_in = psrc_ff | {8'h00, b};
                  EXT_LEFT_BITS'(2): pdst_in = {b, 8'h00};
                  default:           pdst_in = pdst_ff | {8'h00, b};
               endcase
               if (left_ff != '0) begin
                  left_in = left_ff - 1'b1;
               end
               if (left_in == '0) begin
                  pstat_in = ST_FOUND;
                  phase_in = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end

      case (phase_in)
         PH_FIXED:                            res_stat = ST_TRUNCATED;
         PH_EXT_NXT, PH_EXT_LEN, PH_EXT_SKIP: res_stat = ST_EXT_SHORT;
         PH_PORTS:                            res_stat = ST_TRUNCATED;
         default:                             res_stat = pstat_in;
      endcase
      res_found = (res_stat == ST_FOUND);
   end

   always_ff @(posedge clock) begin
      if (reset || (pop && head_entry.last_byte)) begin
         phase_ff <= PH_FIXED;
         kind_ff  <= '0;
         left_ff  <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         psrc_ff  <= '0;
         pdst_ff  <= '0;
         found_ff <= KIND_NONE;
         pstat_ff <= ST_FOUND;
      end else begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         left_ff  <= left_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         psrc_ff  <= psrc_in;
         pdst_ff  <= pdst_in;
         found_ff <= found_in;
         pstat_ff <= pstat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && head_entry.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_entry.last_byte) begin
         o_status_ff <= res_stat;
         o_kind_ff   <= res_found ? found_in : KIND_NONE;
         o_sport_ff  <= res_found ? psrc_in : 16'h0000;
         o_dport_ff  <= res_found ? pdst_in : 16'h0000;
         o_src_ff    <= (res_stat == ST_IPV4) ? 128'd0 : src_in;
         o_dst_ff    <= (res_stat == ST_IPV4) ? 128'd0 : dst_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = o_status_ff;
   assign rsp_chan.transport_kind   = o_kind_ff;
   assign rsp_chan.source_port      = o_sport_ff;
   assign rsp_chan.destination_port = o_dport_ff;
   assign rsp_chan.source_addr_high = o_src_ff[127:64];
   assign rsp_chan.source_addr_low  = o_src_ff[63:0];
   assign rsp_chan.dest_addr_high   = o_dst_ff[127:64];
   assign rsp_chan.dest_addr_low    = o_dst_ff[63:0];

endmodule

`default_nettype wire

// ===== rtl/ipv6_flow_tuple_extractor.sv =====
// The last byte of a request passes through the queue and then the back's output register
// before its result is valid.
// One byte per cycle is taken while the queue has room, and the parser retires one a cycle.
// A packet's result waits in the output register while the next packet's bytes stream in;
// the four-entry queue stalls only when a result is still untaken at the next packet end.
// Reset is synchronous; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_flow_tuple_extractor
   import ifte_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   ifte_req_if.sink    req_chan,
   ifte_rsp_if.source  rsp_chan
);

   logic      queue_ready;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   ifte_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .queue_ready (queue_ready),
      .push        (push),
      .push_entry  (push_entry)
   );

   ifte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .not_full   (queue_ready),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ifte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== dv/ipv6_flow_tuple_extractor_tb.sv =====
`timescale 1ns / 1ps

module ipv6_flow_tuple_extractor_tb;
   import ifte_pkg::*;

   localparam int         EXT_UNIT         = 8;
   localparam logic [7:0] HDR_UNASSIGNED   = 8'd255;
   localparam int         RANDOM_BYTES     = 850;
   localparam int         MIN_PACKETS      = 12;
   localparam int         LONG_HOLD_CYCLES = 300;

   typedef struct {
      status_type  status;
      kind_type    kind;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
   } flow_tuple_type;

   // Parses the accepted bytes on its own and queues the tuple each packet must yield.
   class flow_tuple_board;
      phase_type   phase;
      logic [15:0] pos;
      logic [7:0]  next_hdr;
      logic [11:0] skip_left;
      logic [63:0] src_addr[2];
      logic [63:0] dst_addr[2];
      logic [15:0] src_port;
      logic [15:0] dst_port;
      kind_type    kind;
      status_type  status;

      flow_tuple_type expected_tuples[$];
      int             tuples_checked;
      int             mismatches;
      int             status_seen[6];

      function new();
         clear_flow();
      endfunction

      function void clear_flow();
         phase       = PH_FIXED;
         pos         = '0;
         next_hdr    = '0;
         skip_left   = '0;
         src_addr[0] = '0;
         src_addr[1] = '0;
         dst_addr[0] = '0;
         dst_addr[1] = '0;
         src_port    = '0;
         dst_port    = '0;
         kind        = KIND_NONE;
         status      = ST_FOUND;
      endfunction

      function void open_header();
         case (next_hdr)
            HDR_HOP_BY_HOP, HDR_ROUTING, HDR_FRAGMENT, HDR_DEST_OPT: begin
               phase = PH_EXT_NXT;
            end
            HDR_TCP: begin
               kind      = KIND_TCP;
               skip_left = PORT_BYTES;
               phase     = PH_PORTS;
            end
            HDR_UDP: begin
               kind      = KIND_UDP;
               skip_left = PORT_BYTES;
               phase     = PH_PORTS;
            end
            HDR_NO_NEXT: begin
               status = ST_NO_NEXT;
               phase  = PH_DONE;
            end
            default: begin
               status = ST_UNKNOWN;
               phase  = PH_DONE;
            end
         endcase
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         flow_tuple_type t;
         logic [15:0]    k;
         bit             found;
         case (phase)
            PH_FIXED: begin
               if (pos == 0 && b[7:4] == IP_VERSION_4) begin
                  status = ST_IPV4;
                  phase  = PH_DONE;
               end else begin
                  if (pos == OFF_KIND) next_hdr = b;
                  if (pos >= OFF_SRC_FIRST && pos < OFF_DST_FIRST) begin
                     k = pos - OFF_SRC_FIRST;
                     src_addr[k[3]] |= 64'(b) << (8 * (7 - k[2:0]));
                  end
                  if (pos >= OFF_DST_FIRST && pos < FIXED_LEN) begin
                     k = pos - OFF_DST_FIRST;
                     dst_addr[k[3]] |= 64'(b) << (8 * (7 - k[2:0]));
                  end
                  if (pos == FIXED_LEN - 1) open_header();
               end
            end
            PH_EXT_NXT: begin
               next_hdr = b;
               phase    = PH_EXT_LEN;
            end
            PH_EXT_LEN: begin
               // The next-header and length bytes count toward the (len+1)*8 bytes.
               skip_left = (12'(b) + 12'd1) * 12'(EXT_UNIT) - 12'd2;
               phase     = PH_EXT_SKIP;
            end
            PH_EXT_SKIP: begin
               if (skip_left != 0) skip_left--;
               if (skip_left == 0) open_header();
            end
            PH_PORTS: begin
               case (skip_left)
                  PORT_BYTES:      src_port = {b, 8'h00};
                  PORT_BYTES - 1:  src_port = src_port | 16'(b);
                  PORT_BYTES - 2:  dst_port = {b, 8'h00};
                  default:         dst_port = dst_port | 16'(b);
               endcase
               if (skip_left != 0) skip_left--;
               if (skip_left == 0) begin
                  status = ST_FOUND;
                  phase  = PH_DONE;
               end
            end
            default: ;
         endcase

         if (pos != '1) pos++;
         if (!last) return;

         case (phase)
            PH_FIXED, PH_PORTS:                    t.status = ST_TRUNCATED;
            PH_EXT_NXT, PH_EXT_LEN, PH_EXT_SKIP:   t.status = ST_EXT_SHORT;
            default:                               t.status = status;
         endcase
         found = (t.status == ST_FOUND);
         t.kind     = found ? kind : KIND_NONE;
         t.src_port = found ? src_port : 16'h0000;
         t.dst_port = found ? dst_port : 16'h0000;
         if (t.status == ST_IPV4) begin
            t.src_hi = '0;
            t.src_lo = '0;
            t.dst_hi = '0;
            t.dst_lo = '0;
         end else begin
            t.src_hi = src_addr[0];
            t.src_lo = src_addr[1];
            t.dst_hi = dst_addr[0];
            t.dst_lo = dst_addr[1];
         end
         expected_tuples.push_back(t);
         clear_flow();
      endfunction

      function bit field_differs(string name, logic [63:0] want, logic [63:0] have);
         if (want === have) return 1'b0;
         if (mismatches < 10)
            $display("ERROR: tuple %0d field %s expected %0h got %0h",
                     tuples_checked, name, want, have);
         return 1'b1;
      endfunction

      function void check_tuple(flow_tuple_type got);
         flow_tuple_type want;
         bit             bad;
         if (expected_tuples.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR: tuple with status %0d arrived with no packet pending",
                        got.status);
            mismatches++;
            return;
         end
         want = expected_tuples.pop_front();
         bad  = 1'b0;
         bad |= field_differs("status", want.status, got.status);
         bad |= field_differs("transport_kind", want.kind, got.kind);
         bad |= field_differs("source_port", want.src_port, got.src_port);
         bad |= field_differs("destination_port", want.dst_port, got.dst_port);
         bad |= field_differs("source_addr_high", want.src_hi, got.src_hi);
         bad |= field_differs("source_addr_low", want.src_lo, got.src_lo);
         bad |= field_differs("dest_addr_high", want.dst_hi, got.dst_hi);
         bad |= field_differs("dest_addr_low", want.dst_lo, got.dst_lo);
         if (bad) mismatches++;
         status_seen[int'(want.status)]++;
         tuples_checked++;
      endfunction
   endclass

   logic clock;
   logic reset;

   ifte_req_if req_bus();
   ifte_rsp_if rsp_bus();

   ipv6_flow_tuple_extractor u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   flow_tuple_board board;

   logic [7:0] frame[$];
   logic [7:0] ext_codes[4] = '{HDR_HOP_BY_HOP, HDR_ROUTING, HDR_FRAGMENT, HDR_DEST_OPT};

   bit idling        = 1'b1;
   bit hold_request  = 1'b0;
   int hold_left     = 0;
   int burst_left    = 0;
   int bytes_sent    = 0;
   int packets_sent  = 0;
   int random_bytes  = 0;
   int random_frames = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Both channels are sampled at the rising edge, before the block updates its outputs.
   always @(posedge clock) begin
      flow_tuple_type got;
      if (!reset && req_bus.valid && req_bus.ready)
         board.note_byte(req_bus.data_byte, req_bus.last_byte);
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         got.status   = status_type'(rsp_bus.status);
         got.kind     = kind_type'(rsp_bus.transport_kind);
         got.src_port = rsp_bus.source_port;
         got.dst_port = rsp_bus.destination_port;
         got.src_hi   = rsp_bus.source_addr_high;
         got.src_lo   = rsp_bus.source_addr_low;
         got.dst_hi   = rsp_bus.dest_addr_high;
         got.dst_lo   = rsp_bus.dest_addr_low;
         board.check_tuple(got);
      end
   end

   // Result side: random short stalls while idling, plus one long hold on request.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_bus.ready = 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            burst_left    = $urandom_range(1, 4) - 1;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   function automatic logic [7:0] ipv6_first();
      logic [3:0] ver;
      ver = 4'($urandom_range(0, 15));
      if (ver == IP_VERSION_4) ver = 4'd6;
      return {ver, 4'($urandom)};
   endfunction

   function automatic void put_random(int n);
      repeat (n) frame.push_back(8'($urandom));
   endfunction

   // Address bytes are (random & and_mask) | or_mask, so extremes can be forced.
   function automatic void put_fixed(logic [7:0] first, logic [7:0] nh,
                                     logic [7:0] and_mask, logic [7:0] or_mask);
      frame.push_back(first);
      for (int i = 1; i < FIXED_LEN; i++) begin
         if (i == OFF_KIND)
            frame.push_back(nh);
         else if (i >= OFF_SRC_FIRST)
            frame.push_back((8'($urandom) & and_mask) | or_mask);
         else
            frame.push_back(8'($urandom));
      end
   endfunction

   function automatic void put_ext(logic [7:0] nh, logic [7:0] len);
      frame.push_back(nh);
      frame.push_back(len);
      put_random((int'(len) + 1) * EXT_UNIT - 2);
   endfunction

   function automatic void truncate_to(int n);
      while (frame.size() > n) void'(frame.pop_back());
   endfunction

   function automatic void build_flow();
      logic [7:0] chain[$];
      int         pick;
      repeat ($urandom_range(0, 3)) chain.push_back(ext_codes[$urandom_range(0, 3)]);
      pick = $urandom_range(0, 19);
      if (pick < 9)
         chain.push_back(HDR_TCP);
      else if (pick < 18)
         chain.push_back(HDR_UDP);
      else if (pick == 18)
         chain.push_back(HDR_NO_NEXT);
      else
         chain.push_back(8'($urandom));
      frame.delete();
      put_fixed(ipv6_first(), chain[0], 8'hFF, 8'h00);
      // Mostly short extension headers; now and then a longer one.
      for (int i = 1; i < chain.size(); i++)
         put_ext(chain[i], ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 31))
                                                       : 8'($urandom_range(0, 2)));
      if (chain[chain.size() - 1] == HDR_TCP || chain[chain.size() - 1] == HDR_UDP)
         put_random(4);
      put_random($urandom_range(0, 8));
   endfunction

   task automatic send_byte(logic [7:0] b, logic last);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.data_byte = b;
      req_bus.last_byte = last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
      bytes_sent += frame.size();
      packets_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (board.expected_tuples.size() != 0) @(negedge clock);
   endtask

   task automatic random_packet();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         frame.delete();
         frame.push_back({IP_VERSION_4, 4'($urandom)});
         put_random($urandom_range(0, 8));
      end else if (pick < 75) begin
         build_flow();
      end else if (pick < 92) begin
         build_flow();
         truncate_to($urandom_range(1, frame.size()));
      end else begin
         frame.delete();
         put_random($urandom_range(1, 60));
      end
   endtask

   task automatic run_directed();
      // IPv4, alone and with trailing bytes.
      frame.delete();
      frame.push_back({IP_VERSION_4, 4'h5});
      send_frame();
      frame.delete();
      frame.push_back({IP_VERSION_4, 4'hF});
      put_random(6);
      send_frame();

      // A single IPv6 byte is a truncated fixed header.
      frame.delete();
      frame.push_back(8'h60);
      send_frame();

      // TCP with all-ones addresses and extreme ports.
      frame.delete();
      put_fixed(8'hFF, HDR_TCP, 8'h00, 8'hFF);
      frame.push_back(8'hFF);
      frame.push_back(8'hFF);
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      put_random(3);
      send_frame();

      // UDP with all-zero addresses, version nibble zero.
      frame.delete();
      put_fixed(8'h00, HDR_UDP, 8'h00, 8'h00);
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      frame.push_back(8'hFF);
      frame.push_back(8'hFF);
      send_frame();

      // Ends exactly where an extension header would start.
      frame.delete();
      put_fixed(ipv6_first(), HDR_HOP_BY_HOP, 8'hFF, 8'h00);
      send_frame();

      // Every extension kind in one chain, including a long one.
      frame.delete();
      put_fixed(ipv6_first(), HDR_ROUTING, 8'hFF, 8'h00);
      put_ext(HDR_FRAGMENT, 8'd0);
      put_ext(HDR_DEST_OPT, 8'd1);
      put_ext(HDR_HOP_BY_HOP, 8'd60);
      put_ext(HDR_TCP, 8'd3);
      put_random(9);
      send_frame();

      frame.delete();
      put_fixed(ipv6_first(), HDR_NO_NEXT, 8'hFF, 8'h00);
      put_random(10);
      send_frame();

      frame.delete();
      put_fixed(ipv6_first(), HDR_UNASSIGNED, 8'hFF, 8'h00);
      put_random(3);
      send_frame();

      // Ends after half of the ports.
      frame.delete();
      put_fixed(ipv6_first(), HDR_UDP, 8'hFF, 8'h00);
      put_random(2);
      send_frame();

      // Ends partway through the source address.
      frame.delete();
      put_fixed(ipv6_first(), HDR_TCP, 8'hFF, 8'h00);
      truncate_to(20);
      send_frame();

      // Ends inside an extension header.
      frame.delete();
      put_fixed(ipv6_first(), HDR_DEST_OPT, 8'hFF, 8'h00);
      put_ext(HDR_TCP, 8'd2);
      truncate_to(frame.size() - 5);
      send_frame();
   endtask

   initial begin
      board             = new();
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      run_directed();

      // Hold off results while short packets keep arriving, so the input backs up.
      hold_request = 1'b1;
      repeat (40) begin
         frame.delete();
         frame.push_back({IP_VERSION_4, 4'($urandom)});
         put_random($urandom_range(0, 1));
         send_frame();
      end
      wait_drained();

      while (random_bytes < RANDOM_BYTES || random_frames < MIN_PACKETS) begin
         if (idling && random_bytes >= RANDOM_BYTES * 4 / 5) begin
            wait_drained();
            idling = 1'b0;
         end
         random_packet();
         send_frame();
         random_bytes += frame.size();
         random_frames++;
      end

      wait_drained();
      repeat (8) @(negedge clock);

      $display("Sent %0d packets in %0d bytes; %0d tuples compared, %0d mismatches.",
               packets_sent, bytes_sent, board.tuples_checked, board.mismatches);
      $display("By status found/ipv4/ext-short/no-next/unknown/truncated: %0d/%0d/%0d/%0d/%0d/%0d",
               board.status_seen[0], board.status_seen[1], board.status_seen[2],
               board.status_seen[3], board.status_seen[4], board.status_seen[5]);
      if (board.mismatches == 0 && board.expected_tuples.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
